[rtl/sfm_pkg.sv]
// Shared types and constants for the substring first-match unit.
// Used by sfm_cell, sfm_result_fifo and substring_first_match_unit.
// No dependencies.
package sfm_pkg;

   localparam int SFM_MAX_PATTERN = 32;
   localparam int SFM_OFFSET_BITS = 16;

   localparam int CHAR_W      = 16;
   localparam int PINDEX_W    = 5;
   localparam int PLEN_W      = 6;
   localparam int RSP_OFFS_W  = 16;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Register index, taken from csr_paddr[2].
   localparam logic CSR_PATTERN_LENGTH = 1'b0;

   // Input action codes.
   localparam logic ACT_LOAD_PATTERN = 1'b0;
   localparam logic ACT_TEXT_CHAR    = 1'b1;

   // Broadcast from the top level to every pattern cell.
   typedef struct packed {
      logic                load;
      logic                text;
      logic [CHAR_W-1:0]   char_value;
      logic [PINDEX_W-1:0] pattern_index;
   } sfm_bus_type;

   typedef struct packed {
      logic                  found;
      logic [RSP_OFFS_W-1:0] offset;
      logic [PLEN_W-1:0]     match_length;
      logic                  overflow;
   } sfm_result_type;

endpackage

[rtl/sfm_cell.sv]
// One pattern position: a stored pattern character and its partial-match bit.
// Depends on sfm_pkg.
module sfm_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  sfm_pkg::sfm_bus_type bus,
   input  logic                prev_match,
   output logic                match
);
   import sfm_pkg::*;

   logic [CHAR_W-1:0] pattern_ff;
   logic              match_ff;
   logic              match_in;
   logic              load_here;

   assign load_here = bus.load && (32'(bus.pattern_index) == CELL_INDEX);
   assign match_in  = prev_match && (pattern_ff == bus.char_value);
   assign match     = match_ff;

   always_ff @(posedge clock) begin
      if (load_here) begin
         pattern_ff <= bus.char_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else if (bus.text) begin
         match_ff <= match_in;
      end
   end

endmodule

[rtl/sfm_result_fifo.sv]
// Two-entry result queue that parts the search pipeline from the receiver.
// Depends on sfm_pkg.
module sfm_result_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  sfm_pkg::sfm_result_type  push_data,
   output logic [1:0]               count,
   output logic                     out_valid,
   input  logic                     out_ready,
   output sfm_pkg::sfm_result_type  out_data
);
   import sfm_pkg::*;

   sfm_result_type entry_ff [2];
   logic [1:0]     count_ff;
   logic [1:0]     count_in;
   logic           rd_ptr_ff;
   logic           wr_ptr_ff;
   logic           pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

endmodule

[rtl/substring_first_match_unit.sv]
// Substring first-match unit: top level with the cell chain and result stage.
// Depends on sfm_pkg, sfm_cell and sfm_result_fifo.
//
// Usage: pattern characters are written by index with req_action = load; the
// pattern length is set through the CSR port (register 0, byte address 0).
// Text characters then stream in with req_action = text, the final one of a
// text marked by req_last. The unit accepts one item per clock as long as
// the result queue has room. Every pattern cell compares the incoming
// character in parallel and hands its partial-match bit to its right
// neighbor, so the cell chain sets the rate at one text character per
// cycle. In the next cycle the result stage picks the bit at position
// length-1; a result (first match, or "not found" at the last character) is
// written to a two-entry queue and is offered on rsp_ once the queue holds
// it. At most one result per text. When the receiver stalls, the queue
// holds results and req_ready drops once the queue plus the item in the
// result stage would fill it, unless a result leaves in the same cycle;
// with a ready receiver the input never stalls. Reset clears the length,
// the partial-match bits, the position counter and the queue; pattern
// characters are undefined until written.
module substring_first_match_unit #(
   parameter int MAX_PATTERN = sfm_pkg::SFM_MAX_PATTERN,
   parameter int OFFSET_BITS = sfm_pkg::SFM_OFFSET_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   // Input item channel.
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_action,
   input  logic [sfm_pkg::CHAR_W-1:0]       req_char_value,
   input  logic [sfm_pkg::PINDEX_W-1:0]     req_pattern_index,
   input  logic                             req_last,
   // Result channel.
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_found,
   output logic [sfm_pkg::RSP_OFFS_W-1:0]   rsp_offset,
   output logic [sfm_pkg::PLEN_W-1:0]       rsp_match_length,
   output logic                             rsp_overflow,
   // Configuration port.
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sfm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sfm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sfm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import sfm_pkg::*;

   // Width that holds a clamped length 0..MAX_PATTERN, and a cell select.
   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int SEL_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   // Width for the offset arithmetic: covers both position and length.
   localparam int DIFF_W = ((OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W) + 1;
   localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

   // ---------------------------------------------------------------------
   // Configuration register. pready is tied high, so a write lands at the
   // access phase of the transfer.
   // ---------------------------------------------------------------------
   logic [PLEN_W-1:0] plen_ff;
   logic              csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= '0;
      end else if (csr_write && (csr_paddr[2] == CSR_PATTERN_LENGTH)) begin
         plen_ff <= csr_pwdata[PLEN_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_PATTERN_LENGTH) begin
         csr_prdata = {{(CSR_DATA_W-PLEN_W){1'b0}}, plen_ff};
      end
   end

   // Length clamped to the number of cells.
   logic [LEN_W-1:0] len_clamped;

   always_comb begin
      if (32'(plen_ff) > MAX_PATTERN) begin
         len_clamped = LEN_W'(MAX_PATTERN);
      end else begin
         len_clamped = LEN_W'(plen_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Input acceptance. Room is reserved in the result queue for the item
   // now in the result stage and for the one being accepted, so the result
   // stage never has to stall. A result leaving the queue in this cycle
   // frees its entry in time for the accepted item.
   // ---------------------------------------------------------------------
   logic [1:0] fifo_count;
   logic       s1_valid_ff;
   logic       rsp_pop;
   logic       req_xfer;
   logic       text_xfer;

   assign rsp_pop = rsp_valid && rsp_ready;

   always_comb begin
      case (fifo_count)
         2'd0:    req_ready = 1'b1;
         2'd1:    req_ready = !s1_valid_ff || rsp_pop;
         2'd2:    req_ready = !s1_valid_ff && rsp_pop;
         default: req_ready = 1'b0;
      endcase
   end

   assign req_xfer  = req_valid && req_ready;
   assign text_xfer = req_xfer && (req_action == ACT_TEXT_CHAR);

   // ---------------------------------------------------------------------
   // Text position counter. It saturates at its top value and remembers
   // that it did; the last character of a text restarts it.
   // ---------------------------------------------------------------------
   logic [OFFSET_BITS-1:0] pos_ff;
   logic                   sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sat_ff <= 1'b0;
      end else if (text_xfer) begin
         if (req_last) begin
            pos_ff <= '0;
            sat_ff <= 1'b0;
         end else if (pos_ff == POS_MAX) begin
            sat_ff <= 1'b1;
         end else begin
            pos_ff <= pos_ff + 1'b1;
         end
      end
   end

   // The cells keep the bits of the last character of a text so that the
   // result stage can still read them; the first character of the next text
   // sees its left neighbors as cleared through this flag instead.
   logic restart_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         restart_ff <= 1'b1;
      end else if (text_xfer) begin
         restart_ff <= req_last;
      end
   end

   // ---------------------------------------------------------------------
   // Cell chain. Cell k holds pattern character k; on a text character its
   // bit becomes "left neighbor matched and my character equals the input".
   // ---------------------------------------------------------------------
   sfm_bus_type            bus;
   logic [MAX_PATTERN-1:0] match_vec;
   logic [MAX_PATTERN-1:0] prev_vec;

   assign bus.load          = req_xfer && (req_action == ACT_LOAD_PATTERN);
   assign bus.text          = text_xfer;
   assign bus.char_value    = req_char_value;
   assign bus.pattern_index = req_pattern_index;

   // Position 0 always starts a fresh candidate match.
   assign prev_vec[0] = 1'b1;

   genvar k;
   generate
      for (k = 1; k < MAX_PATTERN; k++) begin : g_link
         assign prev_vec[k] = match_vec[k-1] && !restart_ff;
      end
      for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
         sfm_cell #(
            .CELL_INDEX (k)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .bus        (bus),
            .prev_match (prev_vec[k]),
            .match      (match_vec[k])
         );
      end
   endgenerate

   // ---------------------------------------------------------------------
   // Result stage. It holds what the accepted text character saw at the
   // time of its transfer; the cell bits it reads were written by that same
   // transfer.
   // ---------------------------------------------------------------------
   logic                   s1_last_ff;
   logic                   s1_ovf_ff;
   logic [OFFSET_BITS-1:0] s1_idx_ff;
   logic [LEN_W-1:0]       s1_len_ff;
   logic [PLEN_W-1:0]      s1_plen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= text_xfer;
      end
   end

   always_ff @(posedge clock) begin
      if (text_xfer) begin
         s1_last_ff <= req_last;
         s1_ovf_ff  <= sat_ff;
         s1_idx_ff  <= pos_ff;
         s1_len_ff  <= len_clamped;
         s1_plen_ff <= plen_ff;
      end
   end

   logic              given_ff;
   logic [SEL_W-1:0]  sel;
   logic              hit;
   logic [DIFF_W-1:0] len_m1;
   logic [DIFF_W-1:0] idx_wide;
   logic [DIFF_W-1:0] start;
   logic              push;
   sfm_result_type    push_data;

   assign sel      = SEL_W'(s1_len_ff - 1'b1);
   assign hit      = (s1_len_ff == '0) || match_vec[sel];
   assign len_m1   = DIFF_W'(s1_len_ff) - 1'b1;
   assign idx_wide = DIFF_W'(s1_idx_ff);

   // Match start; a start that would lie before the text is reported as 0.
   always_comb begin
      start = '0;
      if ((s1_len_ff != '0) && (idx_wide >= len_m1)) begin
         start = idx_wide - len_m1;
      end
   end

   // Only the first match of a text is reported; without one, the last
   // character reports "not found".
   assign push = s1_valid_ff && !given_ff && (hit || s1_last_ff);

   always_comb begin
      push_data.found        = hit;
      push_data.offset       = '0;
      push_data.match_length = '0;
      push_data.overflow     = s1_ovf_ff;
      if (hit) begin
         push_data.offset       = RSP_OFFS_W'(start);
         push_data.match_length = s1_plen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         given_ff <= 1'b0;
      end else if (s1_valid_ff) begin
         if (s1_last_ff) begin
            given_ff <= 1'b0;
         end else if (push) begin
            given_ff <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result queue and output channel.
   // ---------------------------------------------------------------------
   sfm_result_type rsp_data;

   sfm_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .count     (fifo_count),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_found        = rsp_data.found;
   assign rsp_offset       = rsp_data.offset;
   assign rsp_match_length = rsp_data.match_length;
   assign rsp_overflow     = rsp_data.overflow;

endmodule

[tb/tb_substring_first_match_unit.sv]
// Self-checking testbench for the substring first-match unit: a search predictor
// with its result checker, stimulus tasks and the top module.
// Depends on sfm_pkg and substring_first_match_unit.
`timescale 1ns / 100ps

class match_result_board;
   logic [sfm_pkg::CHAR_W-1:0]          pattern_chars [sfm_pkg::SFM_MAX_PATTERN];
   logic [sfm_pkg::SFM_MAX_PATTERN-1:0] prefix_hits;
   logic [sfm_pkg::SFM_OFFSET_BITS-1:0] text_pos;
   logic [sfm_pkg::PLEN_W-1:0]          pattern_len;
   bit                                  saturated;
   bit                                  reported;
   sfm_pkg::sfm_result_type             due_results[$];
   int                                  errors;

   function new();
      foreach (pattern_chars[k]) pattern_chars[k] = '0;
      pattern_len = '0;
      errors      = 0;
      restart_text();
   endfunction

   function void restart_text();
      prefix_hits = '0;
      text_pos    = '0;
      saturated   = 1'b0;
      reported    = 1'b0;
   endfunction

   function void set_length(logic [sfm_pkg::PLEN_W-1:0] value);
      pattern_len = value;
   endfunction

   function int pending();
      return due_results.size();
   endfunction

   // Advances the search by one accepted transfer and queues the result it causes.
   function void advance_search(logic action, logic [sfm_pkg::CHAR_W-1:0] ch,
                                logic [sfm_pkg::PINDEX_W-1:0] index, logic last);
      logic [sfm_pkg::SFM_OFFSET_BITS-1:0] char_pos;
      logic [sfm_pkg::SFM_MAX_PATTERN-1:0] next_hits;
      bit                                  was_saturated;
      int                                  eff_len;
      sfm_pkg::sfm_result_type             res;
      if (action == sfm_pkg::ACT_LOAD_PATTERN) begin
         pattern_chars[index] = ch;
         return;
      end
      char_pos      = text_pos;
      was_saturated = saturated;
      if (&text_pos) saturated = 1'b1;
      else text_pos = text_pos + 1'b1;
      next_hits[0] = (pattern_chars[0] == ch);
      for (int k = 1; k < sfm_pkg::SFM_MAX_PATTERN; k++)
         next_hits[k] = prefix_hits[k-1] && (pattern_chars[k] == ch);
      prefix_hits = next_hits;
      eff_len = (pattern_len > sfm_pkg::SFM_MAX_PATTERN) ? sfm_pkg::SFM_MAX_PATTERN
                                                         : int'(pattern_len);
      if (!reported) begin
         if (eff_len == 0 || prefix_hits[eff_len-1]) begin
            res.found        = 1'b1;
            res.offset       = (eff_len > 0 && char_pos >= eff_len - 1)
                               ? sfm_pkg::RSP_OFFS_W'(char_pos - (eff_len - 1)) : '0;
            res.match_length = pattern_len;
            res.overflow     = was_saturated;
            due_results.push_back(res);
            reported = 1'b1;
         end else if (last) begin
            res          = '0;
            res.overflow = was_saturated;
            due_results.push_back(res);
         end
      end
      if (last) restart_text();
   endfunction

   function void check_result(sfm_pkg::sfm_result_type got);
      sfm_pkg::sfm_result_type want;
      if (due_results.size() == 0) begin
         $error("unexpected result: found=%0d offset=%0d match_length=%0d overflow=%0d",
                got.found, got.offset, got.match_length, got.overflow);
         errors++;
         return;
      end
      want = due_results.pop_front();
      if (got.found !== want.found) begin
         $error("found: expected %0d, got %0d", want.found, got.found);
         errors++;
      end
      if (got.offset !== want.offset) begin
         $error("offset: expected %0d, got %0d", want.offset, got.offset);
         errors++;
      end
      if (got.match_length !== want.match_length) begin
         $error("match_length: expected %0d, got %0d", want.match_length, got.match_length);
         errors++;
      end
      if (got.overflow !== want.overflow) begin
         $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
         errors++;
      end
   endfunction
endclass

module tb_substring_first_match_unit;
   import sfm_pkg::*;

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 6;
   // This margin covers the cell chain, the result stage and the result queue
   // with room to spare.
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 1850;
   localparam int MAXP         = SFM_MAX_PATTERN;

   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic                  req_ready;
   logic                  req_action        = ACT_LOAD_PATTERN;
   logic [CHAR_W-1:0]     req_char_value    = '0;
   logic [PINDEX_W-1:0]   req_pattern_index = '0;
   logic                  req_last          = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready         = 1'b0;
   logic                  rsp_found;
   logic [RSP_OFFS_W-1:0] rsp_offset;
   logic [PLEN_W-1:0]     rsp_match_length;
   logic                  rsp_overflow;
   logic                  csr_psel          = 1'b0;
   logic                  csr_penable       = 1'b0;
   logic                  csr_pwrite        = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr         = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata        = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   match_result_board     board = new;
   sfm_result_type        observed;
   int                    cycle_count = 0;

   // Stimulus side: a mirror of the pattern as written, the per-phase symbol
   // set, and the idle settings of the two sides.
   logic [CHAR_W-1:0]     pattern_mirror [MAXP];
   logic [CHAR_W-1:0]     symbols [4];
   int                    src_gap_max = 0;
   int                    rsp_gap_max = 0;
   bit                    rsp_hold_req = 1'b0;

   substring_first_match_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_char_value    (req_char_value),
      .req_pattern_index (req_pattern_index),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_offset        (rsp_offset),
      .rsp_match_length  (rsp_match_length),
      .rsp_overflow      (rsp_overflow),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Both monitors sample at the rising edge, before any register of this
   // time step has updated, so every transfer is seen with its own payload.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         board.advance_search(req_action, req_char_value, req_pattern_index, req_last);
      if (!reset && rsp_valid && rsp_ready) begin
         observed.found        = rsp_found;
         observed.offset       = rsp_offset;
         observed.match_length = rsp_match_length;
         observed.overflow     = rsp_overflow;
         board.check_result(observed);
      end
   end

   // Result receiver. Before each transfer it stalls for a drawn number of
   // cycles; on request it holds off for one long stretch so that the result
   // queue fills and the unit has to stall its input channel.
   initial begin
      int stall;
      wait (reset == 1'b0);
      forever begin
         if (rsp_hold_req) begin
            stall        = HOLD_CYCLES;
            rsp_hold_req = 1'b0;
         end else begin
            stall = (rsp_gap_max > 0) ? $urandom_range(0, rsp_gap_max) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Offers one item after a drawn gap and returns at the edge of its transfer.
   // Valid stays high into the next call when that call draws no gap.
   task automatic offer_item(logic action, logic [CHAR_W-1:0] ch,
                             logic [PINDEX_W-1:0] index, logic last);
      int gap;
      gap = (src_gap_max > 0) ? $urandom_range(0, src_gap_max) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= action;
      req_char_value    <= ch;
      req_pattern_index <= index;
      req_last          <= last;
      if (action == ACT_LOAD_PATTERN) pattern_mirror[index] = ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stops offering, waits so that the monitor has noted the last transfer,
   // waits for every outstanding result, then lets the pipeline settle so
   // that items without a result are finished as well.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Setup and access cycle; the register takes the value at the access edge.
   task automatic write_pattern_length(int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(CSR_PATTERN_LENGTH));
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.set_length(PLEN_W'(value));
   endtask

   function automatic int pick_gap();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 3;
         default: return 19;
      endcase
   endfunction

   // Mostly symbols of the current phase, so that partial matches build up;
   // now and then any pattern entry or a fully random code.
   function automatic logic [CHAR_W-1:0] pick_text_char();
      int r;
      r = $urandom_range(0, 19);
      if (r < 15) return symbols[$urandom_range(0, 3)];
      if (r < 18) return pattern_mirror[$urandom_range(0, MAXP - 1)];
      return CHAR_W'($urandom);
   endfunction

   // One search phase: set the length, refill the pattern from a fresh symbol
   // set, then stream texts of which most carry a copy of the pattern. A few
   // pattern loads land in the middle of a text.
   task automatic run_search_phase(int len_value, int budget, inout int count);
      int                eff_len;
      int                text_len;
      int                embed_at;
      int                sent;
      logic [CHAR_W-1:0] text_q[$];
      sent = 0;
      drain_results();
      write_pattern_length(len_value);
      src_gap_max = pick_gap();
      rsp_gap_max = pick_gap();
      foreach (symbols[a]) symbols[a] = CHAR_W'($urandom);
      eff_len = (len_value > MAXP) ? MAXP : len_value;
      for (int k = 0; k < MAXP; k++) begin
         if (k < eff_len || $urandom_range(0, 3) == 0) begin
            offer_item(ACT_LOAD_PATTERN, symbols[$urandom_range(0, 3)], PINDEX_W'(k),
                       1'($urandom));
            sent++;
         end
      end
      while (sent < budget) begin
         text_len = $urandom_range(1, eff_len + 12);
         text_q.delete();
         for (int i = 0; i < text_len; i++) text_q.push_back(pick_text_char());
         if (eff_len > 0 && $urandom_range(0, 2) != 0) begin
            embed_at = $urandom_range(0, text_len - 1);
            for (int k = 0; k < eff_len; k++) text_q.insert(embed_at + k, pattern_mirror[k]);
         end
         foreach (text_q[i]) begin
            if ($urandom_range(0, 49) == 0) begin
               offer_item(ACT_LOAD_PATTERN, symbols[$urandom_range(0, 3)],
                          PINDEX_W'($urandom), 1'($urandom));
               sent++;
            end
            offer_item(ACT_TEXT_CHAR, text_q[i], PINDEX_W'($urandom),
                       i == text_q.size() - 1);
            sent++;
         end
      end
      count += sent;
   endtask

   initial begin
      int phase;
      int random_count;
      int len_value;
      int r;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every pattern entry is written before the first text character, since
      // all cells compare on every character. The first two entries carry the
      // all-ones and all-zero codes.
      src_gap_max = 19;
      rsp_gap_max = 19;
      for (int k = 0; k < MAXP; k++)
         offer_item(ACT_LOAD_PATTERN,
                    (k == 0) ? 16'hFFFF : (k == 1) ? 16'h0000 : CHAR_W'($urandom),
                    PINDEX_W'(k), 1'b0);

      // Empty pattern: the first text character matches at offset 0, and the
      // rest of the text gives nothing more.
      drain_results();
      write_pattern_length(0);
      offer_item(ACT_TEXT_CHAR, 16'h1234, '0, 1'b0);
      offer_item(ACT_TEXT_CHAR, 16'hFFFF, '1, 1'b1);

      // Single-character pattern found at the very first position.
      drain_results();
      write_pattern_length(1);
      offer_item(ACT_TEXT_CHAR, 16'hFFFF, '0, 1'b1);

      // Two characters: a text without a match ends with a not-found result;
      // the next one matches at offset 1 and a later repeat is ignored.
      drain_results();
      write_pattern_length(2);
      offer_item(ACT_TEXT_CHAR, 16'h0000, '0, 1'b0);
      offer_item(ACT_TEXT_CHAR, 16'hFFFF, '0, 1'b0);
      offer_item(ACT_TEXT_CHAR, 16'h1234, '0, 1'b1);
      offer_item(ACT_TEXT_CHAR, 16'h5555, '0, 1'b0);
      offer_item(ACT_TEXT_CHAR, 16'hFFFF, '0, 1'b0);
      offer_item(ACT_TEXT_CHAR, 16'h0000, '0, 1'b0);
      offer_item(ACT_TEXT_CHAR, 16'hFFFF, '0, 1'b0);
      offer_item(ACT_TEXT_CHAR, 16'h0000, '0, 1'b1);

      // Length change in the middle of a text: the partial-match bits carry
      // over and the new length counts from the next character.
      drain_results();
      write_pattern_length(3);
      offer_item(ACT_TEXT_CHAR, 16'hFFFF, '0, 1'b0);
      drain_results();
      write_pattern_length(2);
      offer_item(ACT_TEXT_CHAR, 16'h0000, '0, 1'b0);
      offer_item(ACT_TEXT_CHAR, 16'h7777, '0, 1'b1);

      // Back-pressure: every one-character text gives a result while the
      // receiver holds off, so the queue fills and the input stalls. The sender
      // then pauses until every result has been taken.
      drain_results();
      write_pattern_length(1);
      src_gap_max  = 0;
      rsp_gap_max  = 0;
      rsp_hold_req = 1'b1;
      offer_item(ACT_LOAD_PATTERN, 16'hC3C3, '0, 1'b0);
      for (int i = 0; i < 40; i++)
         offer_item(ACT_TEXT_CHAR, 16'hC3C3, PINDEX_W'($urandom), 1'b1);
      drain_results();

      // Random phases. The first ones force the empty pattern, the full store
      // depth, a length above the store depth and a single character.
      phase        = 0;
      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         case (phase)
            0: len_value = 0;
            1: len_value = MAXP;
            2: len_value = 63;
            3: len_value = 1;
            default: begin
               r = $urandom_range(0, 9);
               if (r < 7)      len_value = $urandom_range(1, 6);
               else if (r < 9) len_value = $urandom_range(7, MAXP);
               else            len_value = $urandom_range(MAXP + 1, 63);
            end
         endcase
         run_search_phase(len_value, 150, random_count);
         phase++;
      end

      drain_results();
      if (board.errors == 0 && board.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

[files.f]
rtl/sfm_pkg.sv
rtl/sfm_cell.sv
rtl/sfm_result_fifo.sv
rtl/substring_first_match_unit.sv
tb/tb_substring_first_match_unit.sv
